>>> hw/rtl/fcc_pkg.sv
// fcc_pkg: types, constants and the crc word step shared by the frame crc32 checker
// no dependencies; compiled before the interfaces and modules
`default_nettype none

package fcc_pkg;

  localparam int unsigned CrcWidth     = 32;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned LenWidth     = 16;
  localparam int unsigned PosWidth     = 17;
  localparam int unsigned TrailerBytes = 4;

  localparam logic [CrcWidth-1:0]  CRC_POLY      = 32'h04C1_1DB7;
  localparam logic [CrcWidth-1:0]  CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0]  CRC_FINAL_XOR = 32'h0000_0000;
  localparam logic [LenWidth-1:0]  LENGTH_RESET  = 16'd38484;
  localparam logic [ByteWidth-1:0] HEADER_MARK   = 8'hFA;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 frame_start;
  } fcc_item_t;

  typedef struct packed {
    logic                crc_match;
    logic                header_valid;
    logic [CrcWidth-1:0] computed_crc;
  } fcc_result_t;

  // byte zero-extended into the register, then 32 msb-first shift steps;
  // the fixed polynomial flattens into one xor network
  function automatic logic [CrcWidth-1:0] crc_word_step(
    input logic [CrcWidth-1:0]  acc_in,
    input logic [ByteWidth-1:0] data
  );
    logic [CrcWidth-1:0] acc;
    acc = acc_in ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int n = 0; n < CrcWidth; n++) begin
      if (acc[CrcWidth-1]) begin
        acc = {acc[CrcWidth-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[CrcWidth-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fcc_in_if.sv
// fcc_in_if: valid/ready channel carrying one received frame byte
// depends on fcc_pkg for field widths
`default_nettype none

interface fcc_in_if
  import fcc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] data_byte;
  logic                 frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fcc_out_if.sv
// fcc_out_if: valid/ready channel carrying one frame check result
// depends on fcc_pkg for field widths
`default_nettype none

interface fcc_out_if
  import fcc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                crc_match;
  logic                header_valid;
  logic [CrcWidth-1:0] computed_crc;

  modport source (output valid, output crc_match, output header_valid,
                  output computed_crc, input ready);
  modport sink   (input valid, input crc_match, input header_valid,
                  input computed_crc, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fcc_in_reg.sv
// fcc_in_reg: input register stage, holds one accepted item until the frame logic takes it
// depends on fcc_pkg and fcc_in_if
`default_nettype none

module fcc_in_reg
  import fcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  fcc_in_if.sink     in_ch,
  input  wire logic  advance,
  output fcc_item_t  item,
  output logic       item_valid
);

  logic      valid_r;
  fcc_item_t item_r;

  // refill in the same cycle the held item moves on
  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte   <= in_ch.data_byte;
      item_r.frame_start <= in_ch.frame_start;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/fcc_frame_ctl.sv
// fcc_frame_ctl: frame state, byte position, crc register and trailer gathering
// depends on fcc_pkg (crc_word_step, item and result types)
`default_nettype none

module fcc_frame_ctl
  import fcc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [LenWidth-1:0] payload_length,
  input  wire logic                item_valid,
  input  wire fcc_item_t           item,
  input  wire logic                out_free,
  output logic                     advance,
  output logic                     res_load,
  output fcc_result_t              res
);

  logic [CrcWidth-1:0] crc_r, crc_nxt;
  logic [PosWidth-1:0] pos_r, pos_nxt;
  logic [CrcWidth-1:0] trl_r, trl_nxt;
  logic                hdr_r, hdr_nxt;
  logic                act_r, act_nxt;

  logic [CrcWidth-1:0] crc_base;
  logic [PosWidth-1:0] pos_base;
  logic [CrcWidth-1:0] trl_base;
  logic                hdr_base;
  logic                act_base;
  logic [PosWidth-1:0] pos_inc;
  logic [PosWidth-1:0] frame_end;
  logic [CrcWidth-1:0] trl_new;
  logic                in_payload;
  logic                done;

  // a start byte restarts the frame before it is counted
  always_comb begin
    if (item.frame_start) begin
      crc_base = CRC_INIT;
      pos_base = '0;
      trl_base = '0;
      hdr_base = (item.data_byte == HEADER_MARK);
      act_base = 1'b1;
    end else begin
      crc_base = crc_r;
      pos_base = pos_r;
      trl_base = trl_r;
      hdr_base = hdr_r;
      act_base = act_r;
    end
  end

  assign pos_inc    = pos_base + PosWidth'(1);
  assign frame_end  = {1'b0, payload_length} + PosWidth'(TrailerBytes);
  assign in_payload = (pos_base < {1'b0, payload_length});
  // trailer is little-endian: each new byte enters at the top
  assign trl_new    = {item.data_byte, trl_base[CrcWidth-1:ByteWidth]};
  assign done       = act_base && !in_payload && !(pos_inc < frame_end);

  always_comb begin
    crc_nxt = crc_base;
    pos_nxt = pos_base;
    trl_nxt = trl_base;
    hdr_nxt = hdr_base;
    act_nxt = act_base;
    if (act_base) begin
      pos_nxt = pos_inc;
      if (in_payload) begin
        crc_nxt = crc_word_step(crc_base, item.data_byte);
      end else begin
        trl_nxt = trl_new;
        act_nxt = !done;
      end
    end
  end

  // an item with no result never waits on the output side
  assign advance  = item_valid && (!done || out_free);
  assign res_load = advance && done;

  assign res.computed_crc = crc_base ^ CRC_FINAL_XOR;
  assign res.crc_match    = (trl_new == (crc_base ^ CRC_FINAL_XOR));
  assign res.header_valid = hdr_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      pos_r <= '0;
      trl_r <= '0;
      hdr_r <= 1'b0;
      act_r <= 1'b0;
    end else if (advance) begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      trl_r <= trl_nxt;
      hdr_r <= hdr_nxt;
      act_r <= act_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fcc_out_reg.sv
// fcc_out_reg: result register driving the output channel
// depends on fcc_pkg and fcc_out_if
`default_nettype none

module fcc_out_reg
  import fcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire fcc_result_t res,
  output logic             free,
  fcc_out_if.source        out_ch
);

  logic        valid_r;
  fcc_result_t res_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.crc_match    = res_r.crc_match;
  assign out_ch.header_valid = res_r.header_valid;
  assign out_ch.computed_crc = res_r.computed_crc;

endmodule

`default_nettype wire

>>> hw/rtl/frame_crc32_checker_core.sv
// frame_crc32_checker_core: byte-serial frame checker with a 32-bit crc (poly 04C11DB7)
// depends on fcc_pkg, fcc_in_if, fcc_out_if, fcc_in_reg, fcc_frame_ctl, fcc_out_reg
//
// usage:
//   in_ch carries one received byte per item plus a frame start flag; a start
//   item restarts the frame. the first payload_length bytes feed the crc, the
//   next four are the expected crc (little-endian). the fourth trailer byte
//   produces one item on out_ch: crc_match, header_valid (first byte 0xFA) and
//   the computed crc. other bytes produce nothing; bytes outside a frame are
//   dropped until the next start.
//   cfg_wr_en/cfg_wr_data write payload_length; write only while idle.
// timing:
//   one item per cycle unless a held result blocks it. an item accepted on in_ch is
//   held in the input register, goes through the frame logic (one crc byte step)
//   and a verdict lands in the result register as it moves on, shown on out_ch.
// reset: synchronous, active low; frame idle, crc all ones, payload_length
//   back to 38484, both registers empty.
// stall: a held result blocks only an item that would produce another one;
//   in_ch.ready then drops until out_ch.ready frees the result register.
`default_nettype none

module frame_crc32_checker_core
  import fcc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  fcc_in_if.sink                   in_ch,
  fcc_out_if.source                out_ch,
  input  wire logic                cfg_wr_en,
  input  wire logic [LenWidth-1:0] cfg_wr_data
);

  logic [LenWidth-1:0] len_r;
  fcc_item_t           item;
  logic                item_valid;
  logic                advance;
  logic                out_free;
  logic                res_load;
  fcc_result_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LENGTH_RESET;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  fcc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  fcc_frame_ctl u_frame_ctl (
    .clk            (clk),
    .rst_n          (rst_n),
    .payload_length (len_r),
    .item_valid     (item_valid),
    .item           (item),
    .out_free       (out_free),
    .advance        (advance),
    .res_load       (res_load),
    .res            (res)
  );

  fcc_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_load),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking bench for frame_crc32_checker_core, byte stream in, frame verdict out
// depends on fcc_pkg, fcc_in_if, fcc_out_if and the core; predicts each verdict on the fly
module tb;
  import fcc_pkg::*;

  typedef enum {FRAME_GOOD, FRAME_BAD_CRC, FRAME_CUT} frame_kind_t;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 100;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LenWidth-1:0] cfg_wr_data;

  fcc_in_if  in_if();
  fcc_out_if out_if();

  frame_crc32_checker_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // stimulus and expectations
  fcc_item_t   stim_items[$];
  fcc_result_t expected_verdicts[$];
  int unsigned mismatch_count = 0;
  bit          in_took = 1'b0;
  bit          steady_sender = 1'b0;
  bit          hold_arm = 1'b0;

  // mirror of the frame state
  logic [LenWidth-1:0] frame_len_cfg = LENGTH_RESET;
  logic [CrcWidth-1:0] fr_crc = CRC_INIT;
  logic [PosWidth-1:0] fr_pos = '0;
  logic [CrcWidth-1:0] fr_trailer = '0;
  logic                fr_header = 1'b0;
  logic                fr_active = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CrcWidth-1:0] crc_byte_update(input logic [CrcWidth-1:0] crc_in,
                                                          input logic [ByteWidth-1:0] b);
    logic [CrcWidth-1:0] r;
    r = crc_in ^ {{(CrcWidth-ByteWidth){1'b0}}, b};
    repeat (CrcWidth) r = {r[CrcWidth-2:0], 1'b0} ^ (r[CrcWidth-1] ? CRC_POLY : '0);
    return r;
  endfunction

  task automatic frame_check_predict(input logic [ByteWidth-1:0] b, input logic s);
    fcc_result_t verdict;
    if (s) begin
      fr_active  = 1'b1;
      fr_crc     = CRC_INIT;
      fr_pos     = '0;
      fr_trailer = '0;
      fr_header  = (b == HEADER_MARK);
    end
    if (!fr_active) return;
    if (fr_pos < frame_len_cfg) begin
      fr_crc = crc_byte_update(fr_crc, b);
      fr_pos = fr_pos + 1'b1;
      return;
    end
    // trailer arrives little-endian
    fr_trailer = {b, fr_trailer[CrcWidth-1:ByteWidth]};
    fr_pos = fr_pos + 1'b1;
    if (fr_pos < frame_len_cfg + TrailerBytes) return;
    verdict.crc_match    = (fr_trailer == (fr_crc ^ CRC_FINAL_XOR));
    verdict.header_valid = fr_header;
    verdict.computed_crc = fr_crc ^ CRC_FINAL_XOR;
    expected_verdicts = {expected_verdicts, verdict};
    fr_active = 1'b0;
  endtask

  function automatic void add_byte(input logic [ByteWidth-1:0] b, input logic s);
    fcc_item_t it;
    it.data_byte   = b;
    it.frame_start = s;
    stim_items = {stim_items, it};
  endfunction

  // builds one frame for payload length len; a cut frame stops before its last trailer byte
  function automatic int add_frame(input int len, input logic [ByteWidth-1:0] hdr,
                                   input frame_kind_t kind);
    logic [ByteWidth-1:0] bytes[$];
    logic [ByteWidth-1:0] b;
    logic [CrcWidth-1:0]  crc;
    int                   stop;
    crc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? hdr : 8'($urandom);
      bytes = {bytes, b};
      crc = crc_byte_update(crc, b);
    end
    if (kind == FRAME_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < TrailerBytes; i++) bytes = {bytes, crc[8*i +: 8]};
    stop = (kind == FRAME_CUT) ? $urandom_range(1, len + 3) : len + 4;
    for (int i = 0; i < stop; i++) add_byte(bytes[i], i == 0);
    return stop;
  endfunction

  task automatic wait_drained();
    while (stim_items.size() != 0 || in_if.valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_payload_length(input logic [LenWidth-1:0] len);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frame_len_cfg = len;
  endtask

  // sender: bursts of random length separated by random gaps, no gaps while steady_sender
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    fcc_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (gap_left != 0 && !steady_sender) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (stim_items.size() != 0) begin
        nxt = stim_items.pop_front();
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= nxt.data_byte;
        in_if.frame_start <= nxt.frame_start;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall mask, re-picked now and then, plus one long hold-off
  logic [7:0]  stall_mask = 8'hFF;
  logic [2:0]  mask_idx = '0;
  int unsigned mask_age = 0;
  int unsigned hold_left = 0;
  bit          hold_served = 1'b0;

  always @(negedge clk) begin
    if (hold_arm && !hold_served) begin
      hold_served = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (mask_age == 0) begin
        mask_age = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0, 1: stall_mask = 8'hFF;
          2:    stall_mask = 8'($urandom) | 8'h01;
          default: stall_mask = 8'h11;
        endcase
      end else begin
        mask_age--;
      end
      out_if.ready <= stall_mask[mask_idx];
      mask_idx = mask_idx + 1'b1;
    end
  end

  // accepted items feed the predictor, accepted verdicts are checked
  always @(posedge clk) begin
    fcc_result_t want;
    in_took = rst_n && in_if.valid && in_if.ready;
    if (in_took) frame_check_predict(in_if.data_byte, in_if.frame_start);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict match=%0b header=%0b crc=%08h", $time,
                 out_if.crc_match, out_if.header_valid, out_if.computed_crc);
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_if.crc_match !== want.crc_match) begin
          $display("%0t: crc_match expected %0b actual %0b", $time,
                   want.crc_match, out_if.crc_match);
          mismatch_count++;
        end
        if (out_if.header_valid !== want.header_valid) begin
          $display("%0t: header_valid expected %0b actual %0b", $time,
                   want.header_valid, out_if.header_valid);
          mismatch_count++;
        end
        if (out_if.computed_crc !== want.computed_crc) begin
          $display("%0t: computed_crc expected %08h actual %08h", $time,
                   want.computed_crc, out_if.computed_crc);
          mismatch_count++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("frame_crc32_checker_core verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int unsigned budget;
    int unsigned r;
    frame_kind_t kind;
    logic [ByteWidth-1:0] hdr;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.frame_start = 1'b0;
    out_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // at reset length: bytes before any start are dropped, then leave a frame open
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(HEADER_MARK, 1'b1);
    repeat (9) add_byte(8'($urandom), 1'b0);
    wait_drained();
    // shrink the length under the open frame: next byte closes it
    set_payload_length(16'd3);
    add_byte(8'($urandom), 1'b0);
    wait_drained();

    set_payload_length(16'd4);
    void'(add_frame(4, HEADER_MARK, FRAME_GOOD));
    void'(add_frame(4, 8'hFF, FRAME_BAD_CRC));
    void'(add_frame(4, 8'h00, FRAME_CUT));
    void'(add_frame(4, HEADER_MARK, FRAME_GOOD));
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    wait_drained();

    // zero length: the start byte is already trailer
    set_payload_length(16'd0);
    void'(add_frame(0, 8'h00, FRAME_GOOD));
    void'(add_frame(0, 8'h00, FRAME_BAD_CRC));
    add_byte(HEADER_MARK, 1'b1);
    repeat (3) add_byte(8'($urandom), 1'b0);
    wait_drained();

    set_payload_length(16'd1);
    void'(add_frame(1, HEADER_MARK, FRAME_GOOD));
    wait_drained();

    // largest length: open a frame, then shrink the length so the next byte closes it
    set_payload_length(16'hFFFF);
    add_byte(HEADER_MARK, 1'b1);
    repeat (20) add_byte(8'($urandom), 1'b0);
    wait_drained();
    set_payload_length(16'd2);
    add_byte(8'($urandom), 1'b0);
    wait_drained();

    // back-to-back short frames while the receiver holds off
    set_payload_length(16'd1);
    steady_sender = 1'b1;
    hold_arm = 1'b1;
    repeat (60) void'(add_frame(1, HEADER_MARK, FRAME_GOOD));
    wait_drained();
    steady_sender = 1'b0;

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0:       len = $urandom_range(20, 300);
        1:       len = 0;
        default: len = $urandom_range(1, 16);
      endcase
      set_payload_length(16'(len));
      budget = 0;
      while (budget < 160) begin
        r = $urandom_range(0, 9);
        kind = (r < 6) ? FRAME_GOOD : (r < 8) ? FRAME_BAD_CRC : FRAME_CUT;
        hdr = $urandom_range(0, 1) ? HEADER_MARK : 8'($urandom);
        budget += add_frame(len, hdr, kind);
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'b0);
      end
      // sometimes leave a frame open across the length change
      if ($urandom_range(0, 1)) void'(add_frame(len, 8'($urandom), FRAME_CUT));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("frame_crc32_checker_core verification clean");
    end else begin
      $display("frame_crc32_checker_core verification failed");
    end
    $finish;
  end

endmodule

>>> frame_crc32_checker_core.f
hw/rtl/fcc_pkg.sv
hw/rtl/fcc_in_if.sv
hw/rtl/fcc_out_if.sv
hw/rtl/fcc_in_reg.sv
hw/rtl/fcc_frame_ctl.sv
hw/rtl/fcc_out_reg.sv
hw/rtl/frame_crc32_checker_core.sv
tb/tb.sv
